[rtl/linear_block_filter_step_defines.svh]
// assertion shorthands used by lbf_checker
`ifndef LINEAR_BLOCK_FILTER_STEP_DEFINES_SVH
`define LINEAR_BLOCK_FILTER_STEP_DEFINES_SVH

// consequent checked in the same cycle
`define LBF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define LBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lbf_pkg.sv]
package lbf_pkg;

	localparam int MAX_TAPS_DEF  = 64;
	localparam int MAX_ORDER_DEF = 8;
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 18;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W         = PROD_W + 8;
	localparam int LEN_W         = 7;
	localparam int ROW_W         = 7;
	localparam int CFG_IDX_W     = 3;
	localparam int RND_SHIFT     = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_D     = 3'd4;

	typedef enum logic [1:0] {OP_FILTER, OP_LOAD, OP_CLEAR, OP_NONE} op_t;
	typedef enum logic [1:0] {MODE_FIR, MODE_IIR, MODE_SS, MODE_NONE} mode_t;
	typedef enum logic [2:0] {BANK_B, BANK_A, BANK_M, BANK_VB, BANK_VC} bank_t;
	typedef enum logic [2:0] {CS_B, CS_A, CS_M, CS_VB, CS_VC, CS_D} coef_sel_t;
	typedef enum logic [1:0] {DS_HX, DS_HY, DS_SX, DS_U} data_sel_t;
	typedef enum logic [2:0] {ST_IDLE, ST_SWEEP, ST_PUSH, ST_ISSUE, ST_DRAIN, ST_DONE} state_t;

	// one product term handed to the mac
	typedef struct packed {
		logic             valid;
		coef_sel_t        cs;
		data_sel_t        ds;
		logic             neg;
		logic             first;
		logic             last;
		logic [ROW_W-1:0] row;
	} term_t;

	// finished sum, rounded; row 0 is y, row r is state r-1
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] value;
		logic                       clip;
		logic [ROW_W-1:0]           row;
	} res_t;

	function automatic int aw(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// round to nearest, ties up, then clip to q1.15; msb is the clip flag
	function automatic logic [SAMPLE_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] r;
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(32767);
		lo = -hi - ACC_W'(1);
		r = acc + ACC_W'(8192);
		r = r >>> RND_SHIFT;
		if (r > hi)
			return {1'b1, hi[SAMPLE_W-1:0]};
		else if (r < lo)
			return {1'b1, lo[SAMPLE_W-1:0]};
		else
			return {1'b0, r[SAMPLE_W-1:0]};
	endfunction

endpackage

[rtl/lbf_store.sv]
module lbf_store #(
	parameter int MAX_TAPS  = lbf_pkg::MAX_TAPS_DEF,
	parameter int MAX_ORDER = lbf_pkg::MAX_ORDER_DEF,
	localparam int TAW = lbf_pkg::aw(MAX_TAPS),
	localparam int OAW = lbf_pkg::aw(MAX_ORDER),
	localparam int SAW = lbf_pkg::aw(2 * MAX_ORDER),
	localparam int MAW = lbf_pkg::aw(MAX_ORDER * MAX_ORDER)
) (
	input  logic                                clk,
	input  logic                                hx_we,
	input  logic [TAW-1:0]                      hx_waddr,
	input  logic [TAW-1:0]                      hx_raddr,
	input  logic                                hy_we,
	input  logic [TAW-1:0]                      hy_waddr,
	input  logic [TAW-1:0]                      hy_raddr,
	input  logic                                sx_we,
	input  logic [SAW-1:0]                      sx_waddr,
	input  logic [SAW-1:0]                      sx_raddr,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] hist_wdata,
	input  logic                                b_we,
	input  logic                                a_we,
	input  logic [TAW-1:0]                      tap_waddr,
	input  logic [TAW-1:0]                      tap_raddr,
	input  logic                                m_we,
	input  logic [MAW-1:0]                      m_waddr,
	input  logic [MAW-1:0]                      m_raddr,
	input  logic                                vb_we,
	input  logic                                vc_we,
	input  logic [OAW-1:0]                      vec_waddr,
	input  logic [OAW-1:0]                      vb_raddr,
	input  logic [OAW-1:0]                      vc_raddr,
	input  logic signed [lbf_pkg::COEF_W-1:0]   coef_wdata,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] hx_rd_q,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] hy_rd_q,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] sx_rd_q,
	output logic signed [lbf_pkg::COEF_W-1:0]   b_rd_q,
	output logic signed [lbf_pkg::COEF_W-1:0]   a_rd_q,
	output logic signed [lbf_pkg::COEF_W-1:0]   m_rd_q,
	output logic signed [lbf_pkg::COEF_W-1:0]   vb_rd_q,
	output logic signed [lbf_pkg::COEF_W-1:0]   vc_rd_q
);

	logic signed [lbf_pkg::SAMPLE_W-1:0] hx_mem [MAX_TAPS];
	logic signed [lbf_pkg::SAMPLE_W-1:0] hy_mem [MAX_TAPS];
	logic signed [lbf_pkg::SAMPLE_W-1:0] sx_mem [2*MAX_ORDER];
	logic signed [lbf_pkg::COEF_W-1:0]   b_mem  [MAX_TAPS];
	logic signed [lbf_pkg::COEF_W-1:0]   a_mem  [MAX_TAPS];
	logic signed [lbf_pkg::COEF_W-1:0]   m_mem  [MAX_ORDER*MAX_ORDER];
	logic signed [lbf_pkg::COEF_W-1:0]   vb_mem [MAX_ORDER];
	logic signed [lbf_pkg::COEF_W-1:0]   vc_mem [MAX_ORDER];

	always_ff @(posedge clk) begin
		if (hx_we)
			hx_mem[hx_waddr] <= hist_wdata;
		hx_rd_q <= hx_mem[hx_raddr];
	end

	always_ff @(posedge clk) begin
		if (hy_we)
			hy_mem[hy_waddr] <= hist_wdata;
		hy_rd_q <= hy_mem[hy_raddr];
	end

	// two banks: current state and the one being built
	always_ff @(posedge clk) begin
		if (sx_we)
			sx_mem[sx_waddr] <= hist_wdata;
		sx_rd_q <= sx_mem[sx_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[tap_waddr] <= coef_wdata;
		b_rd_q <= b_mem[tap_raddr];
	end

	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[tap_waddr] <= coef_wdata;
		a_rd_q <= a_mem[tap_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we)
			m_mem[m_waddr] <= coef_wdata;
		m_rd_q <= m_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (vb_we)
			vb_mem[vec_waddr] <= coef_wdata;
		vb_rd_q <= vb_mem[vb_raddr];
	end

	always_ff @(posedge clk) begin
		if (vc_we)
			vc_mem[vec_waddr] <= coef_wdata;
		vc_rd_q <= vc_mem[vc_raddr];
	end

endmodule

[rtl/lbf_mac.sv]
module lbf_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbf_pkg::term_t                      term,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] hx_rd,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] hy_rd,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] sx_rd,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] u,
	input  logic signed [lbf_pkg::COEF_W-1:0]   b_rd,
	input  logic signed [lbf_pkg::COEF_W-1:0]   a_rd,
	input  logic signed [lbf_pkg::COEF_W-1:0]   m_rd,
	input  logic signed [lbf_pkg::COEF_W-1:0]   vb_rd,
	input  logic signed [lbf_pkg::COEF_W-1:0]   vc_rd,
	input  logic signed [lbf_pkg::COEF_W-1:0]   feedthrough_d,
	output lbf_pkg::res_t                       res,
	output logic                                busy
);

	lbf_pkg::term_t tag_s1, tag_s2, tag_s3;
	logic signed [lbf_pkg::COEF_W-1:0]   c_sel;
	logic signed [lbf_pkg::SAMPLE_W-1:0] d_sel;
	logic signed [lbf_pkg::PROD_W-1:0]   prod_s2;
	logic signed [lbf_pkg::ACC_W-1:0]    acc_q;
	logic signed [lbf_pkg::ACC_W-1:0]    prod_ext;
	logic signed [lbf_pkg::ACC_W-1:0]    acc_base;
	logic [lbf_pkg::SAMPLE_W:0]          rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= term;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_comb begin
		unique case (tag_s1.cs)
			lbf_pkg::CS_B:  c_sel = b_rd;
			lbf_pkg::CS_A:  c_sel = a_rd;
			lbf_pkg::CS_M:  c_sel = m_rd;
			lbf_pkg::CS_VB: c_sel = vb_rd;
			lbf_pkg::CS_VC: c_sel = vc_rd;
			default:        c_sel = feedthrough_d;
		endcase
		unique case (tag_s1.ds)
			lbf_pkg::DS_HX: d_sel = hx_rd;
			lbf_pkg::DS_HY: d_sel = hy_rd;
			lbf_pkg::DS_SX: d_sel = sx_rd;
			default:        d_sel = u;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s2 <= c_sel * d_sel;
	end

	assign prod_ext = lbf_pkg::ACC_W'(prod_s2);
	assign acc_base = tag_s2.first ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (tag_s2.valid)
			acc_q <= tag_s2.neg ? acc_base - prod_ext : acc_base + prod_ext;
	end

	assign rnd       = lbf_pkg::round_sat(acc_q);
	assign res.valid = tag_s3.valid & tag_s3.last;
	assign res.value = rnd[lbf_pkg::SAMPLE_W-1:0];
	assign res.clip  = rnd[lbf_pkg::SAMPLE_W];
	assign res.row   = tag_s3.row;
	assign busy      = tag_s1.valid | tag_s2.valid | tag_s3.valid;

endmodule

[rtl/lbf_seq.sv]
module lbf_seq #(
	parameter int MAX_TAPS  = lbf_pkg::MAX_TAPS_DEF,
	parameter int MAX_ORDER = lbf_pkg::MAX_ORDER_DEF,
	localparam int TAW = lbf_pkg::aw(MAX_TAPS),
	localparam int OAW = lbf_pkg::aw(MAX_ORDER),
	localparam int SAW = lbf_pkg::aw(2 * MAX_ORDER),
	localparam int MAW = lbf_pkg::aw(MAX_ORDER * MAX_ORDER)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          operation,
	input  logic [2:0]                          coef_bank,
	input  logic [5:0]                          coef_index,
	input  logic signed [lbf_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0] sample,
	input  lbf_pkg::mode_t                      mode,
	input  logic [lbf_pkg::LEN_W-1:0]           num_b,
	input  logic [lbf_pkg::LEN_W-1:0]           num_a,
	input  logic [3:0]                          order,
	input  logic                                out_free,
	input  lbf_pkg::res_t                       res,
	input  logic                                mac_busy,
	output lbf_pkg::term_t                      term,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] sample_q,
	output logic                                done,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] y_q,
	output logic                                clip_q,
	output logic                                hx_we,
	output logic [TAW-1:0]                      hx_waddr,
	output logic [TAW-1:0]                      hx_raddr,
	output logic                                hy_we,
	output logic [TAW-1:0]                      hy_waddr,
	output logic [TAW-1:0]                      hy_raddr,
	output logic                                sx_we,
	output logic [SAW-1:0]                      sx_waddr,
	output logic [SAW-1:0]                      sx_raddr,
	output logic signed [lbf_pkg::SAMPLE_W-1:0] hist_wdata,
	output logic                                b_we,
	output logic                                a_we,
	output logic [TAW-1:0]                      tap_waddr,
	output logic [TAW-1:0]                      tap_raddr,
	output logic                                m_we,
	output logic [MAW-1:0]                      m_waddr,
	output logic [MAW-1:0]                      m_raddr,
	output logic                                vb_we,
	output logic                                vc_we,
	output logic [OAW-1:0]                      vec_waddr,
	output logic [OAW-1:0]                      vb_raddr,
	output logic [OAW-1:0]                      vc_raddr,
	output logic signed [lbf_pkg::COEF_W-1:0]   coef_wdata
);

	localparam int SWEEP_LEN = (MAX_TAPS > MAX_ORDER * MAX_ORDER) ?
		((MAX_TAPS > 2 * MAX_ORDER) ? MAX_TAPS : 2 * MAX_ORDER) :
		((MAX_ORDER * MAX_ORDER > 2 * MAX_ORDER) ? MAX_ORDER * MAX_ORDER : 2 * MAX_ORDER);
	localparam int SWW = $clog2(SWEEP_LEN + 1);
	localparam int LW  = lbf_pkg::LEN_W;

	lbf_pkg::state_t state_q, state_d;
	lbf_pkg::op_t    op;
	logic            sweep_all_q;
	logic [SWW-1:0]  cnt_q;
	logic [TAW-1:0]  hx_head_q, hy_head_q, hx_head_nx, hy_head_nx;
	logic [MAX_ORDER-1:0] sbank_q, ss_mask;
	logic [LW-1:0]   k_q, km1;
	logic [lbf_pkg::ROW_W-1:0] row_q, rwm1;
	logic            fb_q;
	logic [MAW-1:0]  mbase_q;
	logic [LW-1:0]   nb_eff, na_eff, n_eff, ord_w;
	logic            iir_fb, issue_end;
	logic [TAW:0]    hx_diff, hy_diff;
	logic [OAW-1:0]  sx_ridx, sx_widx;
	logic            sweep, push, load, res_hy, res_sx;

	assign op = lbf_pkg::op_t'(operation);

	// lengths outside the range behave as the nearest bound
	assign ord_w  = LW'(order);
	assign nb_eff = (num_b == '0) ? LW'(1) : (num_b > LW'(MAX_TAPS)) ? LW'(MAX_TAPS) : num_b;
	assign na_eff = (num_a == '0) ? LW'(1) : (num_a > LW'(MAX_TAPS)) ? LW'(MAX_TAPS) : num_a;
	assign n_eff  = (ord_w == '0) ? LW'(1) : (ord_w > LW'(MAX_ORDER)) ? LW'(MAX_ORDER) : ord_w;
	assign iir_fb = (mode == lbf_pkg::MODE_IIR) && (na_eff != LW'(1));

	// state entries in use swap banks after a step, the rest stay put
	always_comb begin
		for (int i = 0; i < MAX_ORDER; i++)
			ss_mask[i] = (LW'(i) < n_eff);
	end

	always_comb begin
		if (mode == lbf_pkg::MODE_SS)
			issue_end = (k_q == n_eff) && (row_q == n_eff);
		else if (fb_q)
			issue_end = (k_q == na_eff - LW'(1));
		else
			issue_end = (k_q == nb_eff - LW'(1)) && !iir_fb;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == lbf_pkg::ST_IDLE);
		done     = 1'b0;
		unique case (state_q)
			lbf_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						lbf_pkg::OP_FILTER: begin
							unique case (mode)
								lbf_pkg::MODE_FIR,
								lbf_pkg::MODE_IIR:  state_d = lbf_pkg::ST_PUSH;
								lbf_pkg::MODE_SS:   state_d = lbf_pkg::ST_ISSUE;
								lbf_pkg::MODE_NONE: state_d = lbf_pkg::ST_DONE;
							endcase
						end
						lbf_pkg::OP_CLEAR: state_d = lbf_pkg::ST_SWEEP;
						lbf_pkg::OP_LOAD,
						lbf_pkg::OP_NONE:  state_d = lbf_pkg::ST_IDLE;
					endcase
				end
			end
			lbf_pkg::ST_SWEEP: begin
				if (cnt_q == SWW'(SWEEP_LEN - 1))
					state_d = lbf_pkg::ST_IDLE;
			end
			lbf_pkg::ST_PUSH:  state_d = lbf_pkg::ST_ISSUE;
			lbf_pkg::ST_ISSUE: begin
				if (issue_end)
					state_d = lbf_pkg::ST_DRAIN;
			end
			lbf_pkg::ST_DRAIN: begin
				if (!mac_busy)
					state_d = lbf_pkg::ST_DONE;
			end
			lbf_pkg::ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = lbf_pkg::ST_IDLE;
				end
			end
			default: state_d = lbf_pkg::ST_IDLE;
		endcase
	end

	// term for the current step of the walk
	always_comb begin
		term       = '0;
		term.valid = (state_q == lbf_pkg::ST_ISSUE);
		term.row   = row_q;
		if (mode == lbf_pkg::MODE_SS) begin
			term.first = (k_q == '0);
			term.last  = (k_q == n_eff);
			term.ds    = (k_q == '0) ? lbf_pkg::DS_U : lbf_pkg::DS_SX;
			if (row_q == '0)
				term.cs = (k_q == '0) ? lbf_pkg::CS_D : lbf_pkg::CS_VC;
			else
				term.cs = (k_q == '0) ? lbf_pkg::CS_VB : lbf_pkg::CS_M;
		end else if (fb_q) begin
			term.cs   = lbf_pkg::CS_A;
			term.ds   = lbf_pkg::DS_HY;
			term.neg  = 1'b1;
			term.last = (k_q == na_eff - LW'(1));
		end else begin
			term.cs    = lbf_pkg::CS_B;
			term.ds    = lbf_pkg::DS_HX;
			term.first = (k_q == '0);
			term.last  = (k_q == nb_eff - LW'(1)) && !iir_fb;
		end
	end

	// histories are circular: logical entry i sits at head minus i
	assign km1     = k_q - LW'(1);
	assign rwm1    = row_q - lbf_pkg::ROW_W'(1);
	assign hx_diff = {1'b0, hx_head_q} - {1'b0, TAW'(k_q)};
	assign hy_diff = {1'b0, hy_head_q} - {1'b0, TAW'(km1)};
	assign hx_raddr = hx_diff[TAW] ? TAW'(hx_diff + (TAW+1)'(MAX_TAPS)) : hx_diff[TAW-1:0];
	assign hy_raddr = hy_diff[TAW] ? TAW'(hy_diff + (TAW+1)'(MAX_TAPS)) : hy_diff[TAW-1:0];
	assign tap_raddr = TAW'(k_q);
	assign sx_ridx   = OAW'(km1);
	assign sx_raddr  = sbank_q[sx_ridx] ? SAW'(sx_ridx) + SAW'(MAX_ORDER) : SAW'(sx_ridx);
	assign vb_raddr  = OAW'(rwm1);
	assign vc_raddr  = OAW'(km1);
	assign m_raddr   = mbase_q + MAW'(km1);

	assign hx_head_nx = (hx_head_q == TAW'(MAX_TAPS - 1)) ? '0 : hx_head_q + TAW'(1);
	assign hy_head_nx = (hy_head_q == TAW'(MAX_TAPS - 1)) ? '0 : hy_head_q + TAW'(1);

	// write side
	assign sweep  = (state_q == lbf_pkg::ST_SWEEP);
	assign push   = (state_q == lbf_pkg::ST_PUSH);
	assign load   = (state_q == lbf_pkg::ST_IDLE) && in_valid && (op == lbf_pkg::OP_LOAD);
	assign res_hy = res.valid && (res.row == '0) && (mode == lbf_pkg::MODE_IIR);
	assign res_sx = res.valid && (res.row != '0);
	assign sx_widx = OAW'(res.row - lbf_pkg::ROW_W'(1));

	assign hx_we    = (sweep && (cnt_q < SWW'(MAX_TAPS))) || push;
	assign hx_waddr = sweep ? TAW'(cnt_q) : hx_head_nx;
	assign hy_we    = (sweep && (cnt_q < SWW'(MAX_TAPS))) || res_hy;
	assign hy_waddr = sweep ? TAW'(cnt_q) : hy_head_nx;
	assign sx_we    = (sweep && (cnt_q < SWW'(2 * MAX_ORDER))) || res_sx;
	assign sx_waddr = sweep ? SAW'(cnt_q) :
		(sbank_q[sx_widx] ? SAW'(sx_widx) : SAW'(sx_widx) + SAW'(MAX_ORDER));
	assign hist_wdata = sweep ? '0 : (push ? sample_q : res.value);

	assign b_we = (sweep && sweep_all_q && (cnt_q < SWW'(MAX_TAPS))) ||
		(load && (coef_bank == lbf_pkg::BANK_B) && ({1'b0, coef_index} < LW'(MAX_TAPS)));
	assign a_we = (sweep && sweep_all_q && (cnt_q < SWW'(MAX_TAPS))) ||
		(load && (coef_bank == lbf_pkg::BANK_A) && ({1'b0, coef_index} < LW'(MAX_TAPS)));
	assign m_we = (sweep && sweep_all_q && (cnt_q < SWW'(MAX_ORDER * MAX_ORDER))) ||
		(load && (coef_bank == lbf_pkg::BANK_M) &&
		 (13'(coef_index) < 13'(MAX_ORDER * MAX_ORDER)));
	assign vb_we = (sweep && sweep_all_q && (cnt_q < SWW'(MAX_ORDER))) ||
		(load && (coef_bank == lbf_pkg::BANK_VB) && ({1'b0, coef_index} < LW'(MAX_ORDER)));
	assign vc_we = (sweep && sweep_all_q && (cnt_q < SWW'(MAX_ORDER))) ||
		(load && (coef_bank == lbf_pkg::BANK_VC) && ({1'b0, coef_index} < LW'(MAX_ORDER)));
	assign tap_waddr  = sweep ? TAW'(cnt_q) : TAW'(coef_index);
	assign m_waddr    = sweep ? MAW'(cnt_q) : MAW'(coef_index);
	assign vec_waddr  = sweep ? OAW'(cnt_q) : OAW'(coef_index);
	assign coef_wdata = sweep ? '0 : coef_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbf_pkg::ST_SWEEP;
			sweep_all_q <= 1'b1;
			cnt_q       <= '0;
			hx_head_q   <= '0;
			hy_head_q   <= '0;
			sbank_q     <= '0;
			k_q         <= '0;
			row_q       <= '0;
			fb_q        <= 1'b0;
			mbase_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lbf_pkg::ST_IDLE: begin
					if (in_valid) begin
						cnt_q       <= '0;
						sweep_all_q <= 1'b0;
						k_q         <= '0;
						row_q       <= '0;
						fb_q        <= 1'b0;
						mbase_q     <= '0;
					end
				end
				lbf_pkg::ST_SWEEP: cnt_q <= cnt_q + SWW'(1);
				lbf_pkg::ST_PUSH:  hx_head_q <= hx_head_nx;
				lbf_pkg::ST_ISSUE: begin
					if (mode == lbf_pkg::MODE_SS) begin
						if (k_q == n_eff) begin
							k_q   <= '0;
							row_q <= row_q + lbf_pkg::ROW_W'(1);
							if (row_q != '0)
								mbase_q <= mbase_q + MAW'(n_eff);
						end else begin
							k_q <= k_q + LW'(1);
						end
					end else if (!fb_q && (k_q == nb_eff - LW'(1)) && iir_fb) begin
						fb_q <= 1'b1;
						k_q  <= LW'(1);
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				lbf_pkg::ST_DRAIN: begin
					// new state vector becomes current
					if (!mac_busy && (mode == lbf_pkg::MODE_SS))
						sbank_q <= sbank_q ^ ss_mask;
				end
				lbf_pkg::ST_DONE: ;
				default: ;
			endcase
			if (res_hy)
				hy_head_q <= hy_head_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load == 1'b0 && state_q == lbf_pkg::ST_IDLE && in_valid && op == lbf_pkg::OP_FILTER) begin
			sample_q <= sample;
			y_q      <= '0;
			clip_q   <= 1'b0;
		end else if (res.valid) begin
			clip_q <= clip_q | res.clip;
			if (res.row == '0)
				y_q <= res.value;
		end
	end

endmodule

[rtl/linear_block_filter_step.sv]
// channel   handshake               payload
// in        in_valid / in_ready     operation, coef_bank, coef_index, coef_value, sample
// out       out_valid / out_ready   filtered, saturated
// cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// a load is taken in the idle state and leaves in_ready high; a filter item is
// worked by the single shared mac walking the coefficient and history memories
// one product per cycle. after reset, and after a clear item, a zeroing pass
// runs with in_ready low. a finished result waits in the output register while
// loads and clears go on.
module linear_block_filter_step #(
	parameter int MAX_TAPS  = lbf_pkg::MAX_TAPS_DEF,
	parameter int MAX_ORDER = lbf_pkg::MAX_ORDER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic [2:0]                           coef_bank,
	input  logic [5:0]                           coef_index,
	input  logic signed [lbf_pkg::COEF_W-1:0]    coef_value,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lbf_pkg::SAMPLE_W-1:0]  filtered,
	output logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [lbf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lbf_pkg::COEF_W-1:0]           cfg_data
);

	localparam int TAW = lbf_pkg::aw(MAX_TAPS);
	localparam int OAW = lbf_pkg::aw(MAX_ORDER);
	localparam int SAW = lbf_pkg::aw(2 * MAX_ORDER);
	localparam int MAW = lbf_pkg::aw(MAX_ORDER * MAX_ORDER);

	lbf_pkg::mode_t                    mode_q;
	logic [lbf_pkg::LEN_W-1:0]         num_b_q, num_a_q;
	logic [3:0]                        order_q;
	logic signed [lbf_pkg::COEF_W-1:0] fd_q;

	logic out_valid_q;
	logic signed [lbf_pkg::SAMPLE_W-1:0] filtered_q;
	logic saturated_q;
	logic out_free, done, mac_busy, clip;
	logic signed [lbf_pkg::SAMPLE_W-1:0] y, u;
	lbf_pkg::term_t term;
	lbf_pkg::res_t  res;

	logic hx_we, hy_we, sx_we, b_we, a_we, m_we, vb_we, vc_we;
	logic [TAW-1:0] hx_waddr, hx_raddr, hy_waddr, hy_raddr, tap_waddr, tap_raddr;
	logic [SAW-1:0] sx_waddr, sx_raddr;
	logic [MAW-1:0] m_waddr, m_raddr;
	logic [OAW-1:0] vec_waddr, vb_raddr, vc_raddr;
	logic signed [lbf_pkg::SAMPLE_W-1:0] hist_wdata, hx_rd, hy_rd, sx_rd;
	logic signed [lbf_pkg::COEF_W-1:0]   coef_wdata, b_rd, a_rd, m_rd, vb_rd, vc_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lbf_pkg::MODE_FIR;
			num_b_q <= lbf_pkg::LEN_W'(1);
			num_a_q <= lbf_pkg::LEN_W'(1);
			order_q <= 4'd1;
			fd_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lbf_pkg::CFG_MODE:  mode_q  <= lbf_pkg::mode_t'(cfg_data[1:0]);
				lbf_pkg::CFG_NUM_B: num_b_q <= cfg_data[lbf_pkg::LEN_W-1:0];
				lbf_pkg::CFG_NUM_A: num_a_q <= cfg_data[lbf_pkg::LEN_W-1:0];
				lbf_pkg::CFG_ORDER: order_q <= cfg_data[3:0];
				lbf_pkg::CFG_D:     fd_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register parts the result from the sequencer
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (done)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			filtered_q  <= y;
			saturated_q <= clip;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign saturated = saturated_q;

	lbf_seq #(.MAX_TAPS(MAX_TAPS), .MAX_ORDER(MAX_ORDER)) u_seq (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .coef_bank, .coef_index,
		.coef_value, .sample, .mode(mode_q), .num_b(num_b_q), .num_a(num_a_q),
		.order(order_q), .out_free, .res, .mac_busy, .term, .sample_q(u), .done,
		.y_q(y), .clip_q(clip), .hx_we, .hx_waddr, .hx_raddr, .hy_we, .hy_waddr,
		.hy_raddr, .sx_we, .sx_waddr, .sx_raddr, .hist_wdata, .b_we, .a_we,
		.tap_waddr, .tap_raddr, .m_we, .m_waddr, .m_raddr, .vb_we, .vc_we,
		.vec_waddr, .vb_raddr, .vc_raddr, .coef_wdata
	);

	lbf_store #(.MAX_TAPS(MAX_TAPS), .MAX_ORDER(MAX_ORDER)) u_store (
		.clk, .hx_we, .hx_waddr, .hx_raddr, .hy_we, .hy_waddr, .hy_raddr,
		.sx_we, .sx_waddr, .sx_raddr, .hist_wdata, .b_we, .a_we, .tap_waddr,
		.tap_raddr, .m_we, .m_waddr, .m_raddr, .vb_we, .vc_we, .vec_waddr,
		.vb_raddr, .vc_raddr, .coef_wdata, .hx_rd_q(hx_rd), .hy_rd_q(hy_rd),
		.sx_rd_q(sx_rd), .b_rd_q(b_rd), .a_rd_q(a_rd), .m_rd_q(m_rd),
		.vb_rd_q(vb_rd), .vc_rd_q(vc_rd)
	);

	lbf_mac u_mac (
		.clk, .arst_n, .term, .hx_rd, .hy_rd, .sx_rd, .u, .b_rd, .a_rd, .m_rd,
		.vb_rd, .vc_rd, .feedthrough_d(fd_q), .res, .busy(mac_busy)
	);

endmodule

[rtl/lbf_checker.sv]
`include "linear_block_filter_step_defines.svh"

module lbf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [1:0]                          operation,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [lbf_pkg::SAMPLE_W-1:0] filtered,
	input logic                                saturated
);

	`LBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered) && $stable(saturated), "result changed while stalled")
	`LBF_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && operation == lbf_pkg::OP_FILTER, !in_ready, "sample transfer left input open")
	`LBF_ASSERT_NEXT(a_load_stays_open, in_valid && in_ready && operation == lbf_pkg::OP_LOAD, in_ready, "load transfer stalled input")
	`LBF_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result raised while input open")

endmodule

bind linear_block_filter_step lbf_checker u_lbf_checker (
	.clk, .arst_n, .in_valid, .in_ready, .operation, .out_valid, .out_ready,
	.filtered, .saturated
);

[verif/linear_block_filter_step_checker.sv]
module linear_block_filter_step_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic [2:0]                           coef_bank,
	input  logic [5:0]                           coef_index,
	input  logic signed [lbf_pkg::COEF_W-1:0]    coef_value,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic signed [lbf_pkg::SAMPLE_W-1:0]  filtered,
	input  logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [lbf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lbf_pkg::COEF_W-1:0]           cfg_data,
	output int                                   fails,
	output int                                   pending,
	output int                                   results,
	output int                                   clips
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = lbf_pkg::MAX_TAPS_DEF;
	localparam int NO = lbf_pkg::MAX_ORDER_DEF;
	localparam int SW = lbf_pkg::SAMPLE_W;
	localparam int CW = lbf_pkg::COEF_W;

	typedef struct {
		logic signed [SW-1:0] y;
		logic                 clip;
	} filt_out_t;

	filt_out_t expected_out[$];

	lbf_pkg::mode_t      cur_mode;
	logic [6:0]          len_b, len_a;
	logic [3:0]          ss_order;
	logic signed [CW-1:0] gain_d;

	logic signed [SW-1:0] hist_x[NT];
	logic signed [SW-1:0] hist_y[NT];
	logic signed [SW-1:0] state_x[NO];
	logic signed [CW-1:0] taps_b[NT];
	logic signed [CW-1:0] taps_a[NT];
	logic signed [CW-1:0] mat_a[NO*NO];
	logic signed [CW-1:0] vec_b[NO];
	logic signed [CW-1:0] vec_c[NO];

	function automatic int span(input int v, input int mx);
		if (v < 1)
			return 1;
		return (v > mx) ? mx : v;
	endfunction

	// round half up and clip to q1.15
	function automatic logic signed [SW-1:0] q15(input longint acc, inout logic clipped);
		longint r;
		r = (acc + 8192) >>> 14;
		if (r > 32767) begin
			clipped = 1'b1;
			return 16'sh7fff;
		end
		if (r < -32768) begin
			clipped = 1'b1;
			return 16'sh8000;
		end
		return r[SW-1:0];
	endfunction

	function automatic longint feedforward_sum();
		longint acc;
		acc = 0;
		for (int i = 0; i < span(int'(len_b), NT); i++)
			acc += longint'(taps_b[i]) * longint'(hist_x[i]);
		return acc;
	endfunction

	task automatic step_filter(input logic signed [SW-1:0] u);
		filt_out_t r;
		longint acc, s;
		int n;
		logic signed [SW-1:0] nxt[NO];
		r.y = '0;
		r.clip = 1'b0;
		if (cur_mode == lbf_pkg::MODE_FIR || cur_mode == lbf_pkg::MODE_IIR) begin
			for (int i = NT-1; i > 0; i--)
				hist_x[i] = hist_x[i-1];
			hist_x[0] = u;
			acc = feedforward_sum();
			if (cur_mode == lbf_pkg::MODE_IIR) begin
				for (int i = 1; i < span(int'(len_a), NT); i++)
					acc -= longint'(taps_a[i]) * longint'(hist_y[i-1]);
			end
			r.y = q15(acc, r.clip);
			if (cur_mode == lbf_pkg::MODE_IIR) begin
				for (int i = NT-1; i > 0; i--)
					hist_y[i] = hist_y[i-1];
				hist_y[0] = r.y;
			end
		end else if (cur_mode == lbf_pkg::MODE_SS) begin
			n = span(int'(ss_order), NO);
			acc = longint'(gain_d) * longint'(u);
			for (int i = 0; i < n; i++)
				acc += longint'(vec_c[i]) * longint'(state_x[i]);
			r.y = q15(acc, r.clip);
			for (int i = 0; i < n; i++) begin
				s = longint'(vec_b[i]) * longint'(u);
				for (int j = 0; j < n; j++)
					s += longint'(mat_a[i*n+j]) * longint'(state_x[j]);
				nxt[i] = q15(s, r.clip);
			end
			for (int i = 0; i < n; i++)
				state_x[i] = nxt[i];
		end
		expected_out.push_back(r);
	endtask

	task automatic wipe_history();
		for (int i = 0; i < NT; i++) begin
			hist_x[i] = '0;
			hist_y[i] = '0;
		end
		for (int i = 0; i < NO; i++)
			state_x[i] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		filt_out_t e;
		if (!arst_n) begin
			cur_mode = lbf_pkg::MODE_FIR;
			len_b = 7'd1;
			len_a = 7'd1;
			ss_order = 4'd1;
			gain_d = '0;
			wipe_history();
			for (int i = 0; i < NT; i++) begin
				taps_b[i] = '0;
				taps_a[i] = '0;
			end
			for (int i = 0; i < NO*NO; i++)
				mat_a[i] = '0;
			for (int i = 0; i < NO; i++) begin
				vec_b[i] = '0;
				vec_c[i] = '0;
			end
			expected_out.delete();
			fails = 0;
			results = 0;
			clips = 0;
		end else begin
			if (out_valid && out_ready) begin
				results++;
				if (saturated)
					clips++;
				if (expected_out.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result transfer: filtered %0d saturated %0b",
							filtered, saturated);
				end else begin
					e = expected_out.pop_front();
					if (filtered !== e.y || saturated !== e.clip) begin
						fails++;
						if (fails <= 10)
							$display("result mismatch: filtered exp %0d act %0d, saturated exp %0b act %0b",
								e.y, filtered, e.clip, saturated);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					lbf_pkg::CFG_MODE:  cur_mode = lbf_pkg::mode_t'(cfg_data[1:0]);
					lbf_pkg::CFG_NUM_B: len_b = cfg_data[6:0];
					lbf_pkg::CFG_NUM_A: len_a = cfg_data[6:0];
					lbf_pkg::CFG_ORDER: ss_order = cfg_data[3:0];
					lbf_pkg::CFG_D:     gain_d = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (lbf_pkg::op_t'(operation))
					lbf_pkg::OP_FILTER: step_filter(sample);
					lbf_pkg::OP_CLEAR:  wipe_history();
					lbf_pkg::OP_LOAD: begin
						case (lbf_pkg::bank_t'(coef_bank))
							lbf_pkg::BANK_B:  taps_b[coef_index] = coef_value;
							lbf_pkg::BANK_A:  taps_a[coef_index] = coef_value;
							lbf_pkg::BANK_M:  mat_a[coef_index] = coef_value;
							lbf_pkg::BANK_VB: if (coef_index < NO) vec_b[coef_index] = coef_value;
							lbf_pkg::BANK_VC: if (coef_index < NO) vec_c[coef_index] = coef_value;
							default: ;
						endcase
					end
					default: ;
				endcase
			end
		end
		pending = expected_out.size();
	end

endmodule

[verif/linear_block_filter_step_test.sv]
module linear_block_filter_step_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 300;
	localparam int SW         = lbf_pkg::SAMPLE_W;
	localparam int CW         = lbf_pkg::COEF_W;
	localparam int IW         = lbf_pkg::CFG_IDX_W;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid, in_ready;
	logic [1:0]            operation;
	logic [2:0]            coef_bank;
	logic [5:0]            coef_index;
	logic signed [CW-1:0]  coef_value;
	logic signed [SW-1:0]  sample;
	logic                  out_valid, out_ready;
	logic signed [SW-1:0]  filtered;
	logic                  saturated;
	logic                  cfg_we;
	logic [IW-1:0]         cfg_index;
	logic [CW-1:0]         cfg_data;
	int                    fails, pending, results, clips;
	int                    sent, burst_left, idle_cycles, scale;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	linear_block_filter_step dut (.*);

	linear_block_filter_step_checker chk (.*);

	// receiver stall pattern; a new style is picked at random at the end of each run
	always @(posedge clk or negedge arst_n) begin
		int style, left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			style = 0;
			left = 0;
		end else begin
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			case (style)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 5) == 0);
				default: out_ready <= ((left % 40) < 20);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic push(input lbf_pkg::op_t op, input int bank, input int idx, input int val,
			input int smp);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		coef_bank <= 3'(bank);
		coef_index <= 6'(idx);
		coef_value <= CW'(val);
		sample <= SW'(smp);
		if (op != lbf_pkg::OP_NONE && !(op == lbf_pkg::OP_LOAD &&
				(3'(bank) > lbf_pkg::BANK_VC || (3'(bank) >= lbf_pkg::BANK_VB &&
				6'(idx) >= 6'(lbf_pkg::MAX_ORDER_DEF)))))
			sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load(input lbf_pkg::bank_t bank, input int idx,
			input logic signed [CW-1:0] val);
		push(lbf_pkg::OP_LOAD, int'(bank), idx, int'(val), int'($urandom));
	endtask

	task automatic run(input logic signed [SW-1:0] smp);
		push(lbf_pkg::OP_FILTER, int'($urandom), int'($urandom), int'($urandom), int'(smp));
	endtask

	// quiesce before register writes: loads and clears give no result
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input int m, input int nb, input int na, input int ord,
			input logic signed [CW-1:0] d);
		logic [CW-1:0] vals[5];
		vals = '{CW'(m), CW'(nb), CW'(na), CW'(ord), d};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IW'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] coef_rand();
		return (scale == 0) ? CW'($urandom) : CW'($signed($urandom_range(0, 4095)) - 2048);
	endfunction

	function automatic logic signed [SW-1:0] smp_rand();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return SW'($urandom);
		endcase
	endfunction

	initial begin
		int m, nb, na, ord, n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = lbf_pkg::OP_NONE;
		coef_bank = '0;
		coef_index = '0;
		coef_value = '0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sent = 0;
		burst_left = 0;
		idle_cycles = 0;
		scale = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: saturation both ways, ignored items, clear, odd mode and lengths
		settle();
		set_regs(int'(lbf_pkg::MODE_FIR), 1, 1, 1, '0);
		load(lbf_pkg::BANK_B, 0, 18'sh1ffff);
		run(16'sh7fff);
		run(16'sh8000);
		load(lbf_pkg::BANK_B, 0, 18'sh20000);
		run(16'sh8000);
		run(16'sh7fff);
		load(lbf_pkg::BANK_B, 0, 18'sh04000);
		run(16'sd12345);
		push(lbf_pkg::OP_LOAD, 7, 3, 'h1ffff, 0);
		push(lbf_pkg::OP_LOAD, int'(lbf_pkg::BANK_VB), 63, 'h1ffff, 0);
		push(lbf_pkg::OP_NONE, 5, 63, 'h20000, 'h7fff);
		push(lbf_pkg::OP_CLEAR, 0, 0, 0, 0);
		run(16'sd1);
		settle();
		set_regs(int'(lbf_pkg::MODE_NONE), 0, 0, 0, 18'sh20000);
		run(16'sd100);
		settle();
		set_regs(int'(lbf_pkg::MODE_IIR), 2, 2, 1, 18'sh1ffff);
		load(lbf_pkg::BANK_B, 1, 18'sh02000);
		load(lbf_pkg::BANK_A, 1, 18'sh3e000);
		run(16'sh4000);
		run(16'sh7fff);
		settle();
		set_regs(int'(lbf_pkg::MODE_SS), 127, 127, 0, 18'sh1ffff);
		load(lbf_pkg::BANK_VB, 0, 18'sh04000);
		load(lbf_pkg::BANK_VC, 0, 18'sh02000);
		load(lbf_pkg::BANK_M, 0, 18'sh03000);
		run(16'sh7fff);
		run(16'sh8000);

		// random phases: config, coefficient set for the mode, then samples and noise
		while (sent < 1250) begin
			settle();
			m = ($urandom_range(0, 19) == 0) ? int'(lbf_pkg::MODE_NONE) :
				int'($urandom_range(0, 2));
			if ($urandom_range(0, 7) == 0) begin
				nb = ($urandom_range(0, 1) == 0) ? 64 : int'($urandom_range(0, 127));
				na = ($urandom_range(0, 1) == 0) ? 64 : int'($urandom_range(0, 127));
				ord = ($urandom_range(0, 1) == 0) ? 8 : int'($urandom_range(0, 15));
			end else begin
				nb = $urandom_range(1, 8);
				na = $urandom_range(1, 6);
				ord = $urandom_range(1, 4);
			end
			scale = $urandom_range(0, 2);
			set_regs(m, nb, na, ord, ($urandom_range(0, 1) == 0) ? CW'($urandom) : coef_rand());
			if (m == int'(lbf_pkg::MODE_FIR) || m == int'(lbf_pkg::MODE_IIR)) begin
				for (int i = 0; i < ((nb > 64 || nb == 0) ? 64 : nb); i++)
					load(lbf_pkg::BANK_B, i, coef_rand());
				if (m == int'(lbf_pkg::MODE_IIR))
					for (int i = 1; i < ((na > 64 || na == 0) ? 64 : na); i++)
						load(lbf_pkg::BANK_A, i, coef_rand());
			end else if (m == int'(lbf_pkg::MODE_SS)) begin
				n = (ord > 8) ? 8 : ((ord == 0) ? 1 : ord);
				for (int i = 0; i < n * n; i++)
					load(lbf_pkg::BANK_M, i, coef_rand());
				for (int i = 0; i < n; i++) begin
					load(lbf_pkg::BANK_VB, i, coef_rand());
					load(lbf_pkg::BANK_VC, i, coef_rand());
				end
			end
			if ($urandom_range(0, 2) == 0)
				push(lbf_pkg::OP_CLEAR, int'($urandom), int'($urandom), int'($urandom),
					int'($urandom));
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(0, 4) != 0)
					run(smp_rand());
				else
					push(lbf_pkg::op_t'($urandom_range(0, 3)), int'($urandom), int'($urandom),
						int'($urandom), int'($urandom));
			end
		end

		settle();
		$display("sent %0d input items across mode, length and coefficient phases", sent);
		$display("checked %0d results, %0d of them saturated", results, clips);
		if (fails == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
